[design/edmf_pkg.sv]
// ============================================================================
// edmf_pkg - shared definitions of the echo distance median filter
// Widths, conversion scales, register indexes and the link between cells.
// ============================================================================
package edmf_pkg;

    localparam int DIST_W      = 19;
    localparam int TIME_W      = 16;
    localparam int SCALE_W     = 13;
    localparam int SCALE_SHIFT = 10;
    localparam int AGE_W       = 5;   // holds any age of a window up to 32 readings
    localparam int WINDOW_DEF  = 5;
    localparam int CFG_IDX_W   = 1;

    localparam logic [SCALE_W-1:0] CM_SCALE   = 13'd4496;
    localparam logic [SCALE_W-1:0] INCH_SCALE = 13'd1769;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_SELECT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_THRESHOLD = 1'b1;

    // what one cell shows its neighbors
    typedef struct packed {
        logic [DIST_W-1:0] value;   // stored reading
        logic [AGE_W-1:0]  age;     // items since this reading was written
        logic              le;      // reading <= incoming distance
        logic              ge_k;    // this cell or one to its left holds the oldest
    } t_link;

endpackage

[design/edmf_in_if.sv]
// ============================================================================
// edmf_in_if - input channel of the echo distance median filter
// Valid/ready channel carrying one echo time per transfer.
// ============================================================================
interface edmf_in_if
    import edmf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] echo_time;

    modport source (output valid, output echo_time, input ready);
    modport sink   (input valid, input echo_time, output ready);
endinterface

[design/edmf_out_if.sv]
// ============================================================================
// edmf_out_if - result channel of the echo distance median filter
// Valid/ready channel carrying one filtered result per transfer.
// ============================================================================
interface edmf_out_if
    import edmf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] smoothed_distance;
    logic [DIST_W-1:0] current_distance;
    logic              object_near;

    modport source (output valid, output smoothed_distance, output current_distance,
                    output object_near, input ready);
    modport sink   (input valid, input smoothed_distance, input current_distance,
                    input object_near, output ready);
endinterface

[design/edmf_cell.sv]
// ============================================================================
// edmf_cell - one slot of the sorted reading chain
// Drops the oldest reading and inserts the new one while keeping sort order.
// ============================================================================
module edmf_cell
    import edmf_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF,
    parameter int INDEX  = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_insert,
    input  logic [DIST_W-1:0] i_x,
    input  t_link             i_left,
    input  t_link             i_right,
    output t_link             o_link
);

    logic [DIST_W-1:0] r_value, n_value;
    logic [AGE_W-1:0]  r_age, n_age;

    logic              w_le;
    logic              w_ge_k;
    logic [DIST_W-1:0] w_own_v, w_prev_v;
    logic [AGE_W-1:0]  w_own_age, w_prev_age;
    logic              w_own_le, w_prev_le;

    assign w_le   = (r_value <= i_x);
    assign w_ge_k = i_left.ge_k | (r_age == AGE_W'(WINDOW - 1));

    // this slot and the one to the left, with the oldest reading squeezed out
    assign w_own_v    = w_ge_k ? i_right.value : r_value;
    assign w_own_age  = w_ge_k ? i_right.age   : r_age;
    assign w_own_le   = w_ge_k ? i_right.le    : w_le;
    assign w_prev_v   = i_left.ge_k ? r_value : i_left.value;
    assign w_prev_age = i_left.ge_k ? r_age   : i_left.age;
    assign w_prev_le  = i_left.ge_k ? w_le    : i_left.le;

    always_comb begin
        priority if (w_own_le) begin
            n_value = w_own_v;
            n_age   = w_own_age + AGE_W'(1);
        end else if (w_prev_le) begin
            n_value = i_x;
            n_age   = '0;
        end else begin
            n_value = w_prev_v;
            n_age   = w_prev_age + AGE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
            r_age   <= AGE_W'(INDEX);
        end else if (i_insert) begin
            r_value <= n_value;
            r_age   <= n_age;
        end
    end

    assign o_link.value = r_value;
    assign o_link.age   = r_age;
    assign o_link.le    = w_le;
    assign o_link.ge_k  = w_ge_k;

endmodule

[design/echo_distance_median_filter_unit.sv]
// ============================================================================
// echo_distance_median_filter_unit - echo time to filtered distance
// Converts echo times to distance and returns the median of the last readings.
// ============================================================================
// Each accepted echo time (microseconds) is scaled to 1/256 of a centimetre
// ((t*4496)>>10) or of an inch ((t*1769)>>10), chosen by unit_select, and
// replaces the oldest of WINDOW readings. The readings live in a chain of
// WINDOW cells kept in ascending order; every cell carries the age of its
// reading, so one insert step drops the oldest and slots the new one in
// place. The result holds the median (middle cell, or the truncated mean of
// the two middle cells for an even window), the unfiltered distance, and a
// near flag (distance <= near_threshold). Readings start as zero after reset
// and count toward the median until overwritten. From transfer to result an
// item passes in order through the time register, the scale multiplier, the
// insert step through the cell chain and the output register, whose load
// waits while an untaken result is held. Input ready is high only while no
// item is in work; a finished result waits in the output register while the
// next item enters. Configuration writes take effect for items accepted after
// them; stored readings keep the unit they were converted in.
module echo_distance_median_filter_unit
    import edmf_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIST_W-1:0]    i_cfg_data,
    edmf_in_if.sink              i_in,
    edmf_out_if.source           o_out
);

    // sequencer, one-hot
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CONV   = 4'b0010,
        S_INSERT = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic              r_unit_select;
    logic [DIST_W-1:0] r_near_threshold;

    // item in work
    logic [TIME_W-1:0] r_time;
    logic [DIST_W-1:0] r_dist;

    // output register
    logic              r_out_valid, n_out_valid;
    logic [DIST_W-1:0] r_smooth;
    logic [DIST_W-1:0] r_cur;
    logic              r_near;

    logic                      w_in_xfer;
    logic                      w_load;
    logic [SCALE_W-1:0]        w_scale;
    logic [TIME_W+SCALE_W-1:0] w_product;
    logic [DIST_W-1:0]         w_median;

    // cell chain; links[0] and links[WINDOW+1] are the tie-offs at both ends
    t_link             w_link [WINDOW+2];
    logic [WINDOW-1:0] w_old;
    logic [WINDOW-1:0] w_sorted;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_load     = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    // --- configuration -----------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_select    <= 1'b0;
            r_near_threshold <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_UNIT_SELECT:    r_unit_select    <= i_cfg_data[0];
                CFG_NEAR_THRESHOLD: r_near_threshold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // --- sequencer ---------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_in_xfer) n_state = S_CONV;
            S_CONV:   n_state = S_INSERT;
            S_INSERT: n_state = S_DONE;
            S_DONE:   if (w_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // --- conversion --------------------------------------------------------
    assign w_scale   = r_unit_select ? INCH_SCALE : CM_SCALE;
    assign w_product = {{SCALE_W{1'b0}}, r_time} * {{TIME_W{1'b0}}, w_scale};

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_time <= i_in.echo_time;
        end
        if (r_state == S_CONV) begin
            // drop the ten fraction bits of the scale
            r_dist <= w_product[SCALE_SHIFT +: DIST_W];
        end
    end

    // --- sorted cell chain -------------------------------------------------
    // left end: nothing older to the left, and an empty slot counts as low
    assign w_link[0].value = '0;
    assign w_link[0].age   = '0;
    assign w_link[0].le    = 1'b1;
    assign w_link[0].ge_k  = 1'b0;
    // right end: no reading past the last cell
    assign w_link[WINDOW+1].value = '0;
    assign w_link[WINDOW+1].age   = '0;
    assign w_link[WINDOW+1].le    = 1'b0;
    assign w_link[WINDOW+1].ge_k  = 1'b1;

    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        edmf_cell #(
            .WINDOW (WINDOW),
            .INDEX  (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_insert (r_state == S_INSERT),
            .i_x      (r_dist),
            .i_left   (w_link[g]),
            .i_right  (w_link[g+2]),
            .o_link   (w_link[g+1])
        );
        assign w_old[g]    = (w_link[g+1].age == AGE_W'(WINDOW - 1));
        assign w_sorted[g] = (w_link[g].value <= w_link[g+1].value);
    end

    // --- median ------------------------------------------------------------
    if ((WINDOW % 2) == 0) begin : g_even
        logic [DIST_W:0] w_sum;
        assign w_sum    = {1'b0, w_link[WINDOW/2].value} + {1'b0, w_link[WINDOW/2+1].value};
        assign w_median = w_sum[DIST_W:1];
    end else begin : g_odd
        assign w_median = w_link[WINDOW/2+1].value;
    end

    // --- output register ---------------------------------------------------
    always_comb begin
        n_out_valid = r_out_valid;
        priority if (w_load) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_smooth <= w_median;
            r_cur    <= r_dist;
            r_near   <= (r_dist <= r_near_threshold);
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.smoothed_distance = r_smooth;
    assign o_out.current_distance  = r_cur;
    assign o_out.object_near       = r_near;

    // --- assertions --------------------------------------------------------
    // exactly one cell holds the oldest reading
    a_one_oldest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(w_old))
        else $error("cell ages lost their oldest marker");

    // the chain stays in ascending order
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        &w_sorted)
        else $error("cell chain out of order");

    // a finished result always lands in the output register
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_state == S_IDLE) && r_out_valid)
        else $error("result not loaded");

    // an accepted item leaves idle for conversion
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == S_CONV) && !i_in.ready)
        else $error("accepted item not started");

endmodule

[dv/tb_echo_distance_median_filter_unit.sv]
// ============================================================================
// tb_echo_distance_median_filter_unit - checks echo time to filtered distance
// Drives echo times through the valid/ready input under random idling and
// backpressure, mirrors the reading ring and the median in a local predictor,
// and compares every result field by field across several unit and
// threshold settings.
// ============================================================================
module tb_echo_distance_median_filter_unit
    import edmf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN              = WINDOW_DEF;
    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 160;
    localparam int HOLD_TRIGGER     = 400;   // transfers before the long hold
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int NUM_PHASES       = 7;
    localparam int ITEMS_PER_PHASE  = 250;
    localparam int MAX_PRINTS       = 50;

    // directed echo times, first with centimetres and threshold zero
    localparam logic [TIME_W-1:0] CM_ECHOES [12] = '{
        16'd0, 16'd65535, 16'd65535, 16'd1, 16'd32768, 16'd65534,
        16'd2, 16'd1000, 16'd1000, 16'd0, 16'd0, 16'd0
    };
    // then with inches and a threshold that 1000 us hits exactly
    localparam logic [TIME_W-1:0] INCH_ECHOES [10] = '{
        16'd1000, 16'd1001, 16'd999, 16'd65535, 16'd0,
        16'd1, 16'd578, 16'd2000, 16'd65535, 16'd3
    };
    localparam logic [DIST_W-1:0] INCH_1000_DIST = 19'd1727;
    localparam logic [DIST_W-1:0] MAX_DIST       = 19'd287739;

    typedef struct packed {
        logic [DIST_W-1:0] smoothed;
        logic [DIST_W-1:0] current;
        logic              near;
    } t_dist_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DIST_W-1:0]    i_cfg_data;

    edmf_in_if  in_ch ();
    edmf_out_if out_ch ();

    echo_distance_median_filter_unit #(
        .WINDOW (WIN)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // ------------------------------------------------------------------------
    // Predictor state: a mirror of the reading ring and both registers
    // ------------------------------------------------------------------------
    logic [DIST_W-1:0] ring_copy [WIN];
    int                ring_slot;
    logic              unit_copy;
    logic [DIST_W-1:0] near_limit_copy;

    logic [TIME_W-1:0] echo_backlog [$];      // echo times not yet transferred
    t_dist_result      awaited_readings [$];  // predicted results, oldest first
    t_dist_result      want_reading;

    logic echo_taken   = 1'b0;  // front of the backlog went out at the last edge
    logic sink_blocked;         // long receiver hold in progress
    logic calm_phase;           // no idling on either side
    int   src_gap      = 0;
    int   snk_gap      = 0;
    int   items_taken  = 0;
    int   results_seen = 0;
    int   mismatch_count = 0;
    int   idle_cycles  = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Scale an echo time to 1/256 of the selected unit, truncating.
    function automatic logic [DIST_W-1:0] to_distance(logic [TIME_W-1:0] t, logic inch);
        logic [31:0] prod;
        prod = 32'(t) * (inch ? 32'(INCH_SCALE) : 32'(CM_SCALE));
        return DIST_W'(prod >> SCALE_SHIFT);
    endfunction

    // Sort a copy of the ring and take the middle; mean of two for even sizes.
    function automatic logic [DIST_W-1:0] ring_median();
        logic [DIST_W-1:0] sorted [WIN];
        logic [DIST_W-1:0] v;
        logic [DIST_W:0]   pair;
        int                j;
        for (int i = 0; i < WIN; i++) sorted[i] = ring_copy[i];
        for (int i = 1; i < WIN; i++) begin
            v = sorted[i];
            j = i - 1;
            while (j >= 0 && sorted[j] > v) begin
                sorted[j + 1] = sorted[j];
                j--;
            end
            sorted[j + 1] = v;
        end
        if (WIN % 2 == 0) begin
            pair = {1'b0, sorted[WIN / 2 - 1]} + {1'b0, sorted[WIN / 2]};
            return pair[DIST_W:1];
        end
        return sorted[WIN / 2];
    endfunction

    // Store the new reading over the oldest slot and form the result.
    function automatic t_dist_result insert_and_filter(logic [TIME_W-1:0] t);
        t_dist_result      r;
        logic [DIST_W-1:0] d;
        d = to_distance(t, unit_copy);
        ring_copy[ring_slot] = d;
        ring_slot  = (ring_slot + 1 >= WIN) ? 0 : ring_slot + 1;
        r.smoothed = ring_median();
        r.current  = d;
        r.near     = (d <= near_limit_copy);
        return r;
    endfunction

    // Random echo time: uniform in three of eight draws, else edges, repeats and threshold hits.
    function automatic logic [TIME_W-1:0] pick_echo(logic [TIME_W-1:0] prev);
        logic [31:0] target;
        logic [31:0] t;
        case ($urandom_range(0, 7))
            0, 1, 2: return TIME_W'($urandom);
            3:       return TIME_W'($urandom_range(0, 64));
            4:       return TIME_W'(32'hFFFF - $urandom_range(0, 64));
            5: begin
                // land on or next to the near/far boundary
                target = ({13'd0, near_limit_copy} << SCALE_SHIFT)
                         / (unit_copy ? 32'(INCH_SCALE) : 32'(CM_SCALE));
                t = ((target > 0) ? target - 1 : 0) + $urandom_range(0, 2);
                return (t > 32'hFFFF) ? 16'hFFFF : TIME_W'(t);
            end
            6:       return prev;
            default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("[%0t] mismatch on %s: got %0d, want %0d (result %0d)",
                     $time, what, got, want, results_seen);
    endtask

    // Write one register at a falling edge and mirror it in the predictor.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIST_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_UNIT_SELECT:    unit_copy       = data[0];
            CFG_NEAR_THRESHOLD: near_limit_copy = data;
            default: ;
        endcase
    endtask

    // Hold until every echo went out and every result came back, then settle.
    task automatic wait_for_idle();
        while (echo_backlog.size() != 0 || awaited_readings.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Input driver: offer the front of the backlog, hold it until transferred
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !echo_taken) begin
            // hold the offered item until the block takes it
        end else if (src_gap > 0) begin
            src_gap     <= src_gap - 1;
            in_ch.valid <= 1'b0;
        end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
            // start an idle burst
            src_gap     <= $urandom_range(0, 2);
            in_ch.valid <= 1'b0;
        end else if (echo_backlog.size() > 0) begin
            in_ch.valid     <= 1'b1;
            in_ch.echo_time <= echo_backlog[0];
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: random stall bursts, plus the long hold when requested
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n || sink_blocked) begin
            out_ch.ready <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap      <= snk_gap - 1;
            out_ch.ready <= 1'b0;
        end else if (!calm_phase && $urandom_range(0, 4) == 0) begin
            snk_gap      <= $urandom_range(0, 2);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Block the receiver for a long stretch once traffic is flowing, so the
    // output register fills and the block drops its input ready.
    initial begin : long_receiver_hold
        sink_blocked = 1'b0;
        wait (items_taken >= HOLD_TRIGGER);
        @(negedge i_clk);
        sink_blocked <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
        sink_blocked <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Monitor: check results first, then predict for the echo taken this edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            echo_taken <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (awaited_readings.size() == 0) begin
                    report_mismatch("result with nothing awaited",
                                    32'(out_ch.smoothed_distance), 0);
                end else begin
                    want_reading = awaited_readings.pop_front();
                    if (out_ch.smoothed_distance !== want_reading.smoothed)
                        report_mismatch("smoothed_distance", 32'(out_ch.smoothed_distance),
                                        32'(want_reading.smoothed));
                    if (out_ch.current_distance !== want_reading.current)
                        report_mismatch("current_distance", 32'(out_ch.current_distance),
                                        32'(want_reading.current));
                    if (out_ch.object_near !== want_reading.near)
                        report_mismatch("object_near", 32'(out_ch.object_near),
                                        32'(want_reading.near));
                end
            end
            echo_taken <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready) begin
                awaited_readings.push_back(insert_and_filter(in_ch.echo_time));
                void'(echo_backlog.pop_front());
                items_taken++;
            end
        end
    end

    // Watchdog: end the run when neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("** echo_distance_median_filter_unit: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus: directed items, then one random phase per register setting
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [TIME_W-1:0] prev_echo;
        logic              phase_unit;
        logic [DIST_W-1:0] phase_limit;

        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_UNIT_SELECT;
        i_cfg_data      = '0;
        in_ch.valid     = 1'b0;
        in_ch.echo_time = '0;
        out_ch.ready    = 1'b0;
        calm_phase      = 1'b0;
        for (int i = 0; i < WIN; i++) ring_copy[i] = '0;
        ring_slot       = 0;
        unit_copy       = 1'b0;
        near_limit_copy = '0;
        prev_echo       = '0;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: centimetres, threshold zero. The first items still
        // see zeros in the unwritten slots; zero distance meets the threshold.
        @(posedge i_clk);
        foreach (CM_ECHOES[i]) echo_backlog.push_back(CM_ECHOES[i]);
        wait_for_idle();

        // Switch to inches with junk above the unit bit; older readings keep
        // centimetres. Threshold equals the 1000 us distance exactly.
        write_reg(CFG_UNIT_SELECT, 19'h7FFFF);
        write_reg(CFG_NEAR_THRESHOLD, INCH_1000_DIST);
        @(posedge i_clk);
        foreach (INCH_ECHOES[i]) echo_backlog.push_back(INCH_ECHOES[i]);
        wait_for_idle();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin phase_unit = 1'b0; phase_limit = MAX_DIST;       end
                1: begin phase_unit = 1'b1; phase_limit = '0;             end
                2: begin phase_unit = 1'b0; phase_limit = DIST_W'($urandom); end
                3: begin phase_unit = 1'b1; phase_limit = 19'h7FFFF;      end
                4: begin
                    phase_unit  = 1'b0;
                    phase_limit = DIST_W'($urandom_range(0, 287739));
                end
                5: begin
                    phase_unit  = 1'b1;
                    phase_limit = DIST_W'($urandom_range(20000, 80000));
                end
                default: begin
                    phase_unit  = 1'($urandom);
                    phase_limit = DIST_W'($urandom_range(0, 287739));
                end
            endcase
            // the last phase runs without idling on either side
            calm_phase <= (phase == NUM_PHASES - 1);
            // random upper bits on the unit write; only bit zero counts
            write_reg(CFG_UNIT_SELECT, {(DIST_W-1)'($urandom), phase_unit});
            write_reg(CFG_NEAR_THRESHOLD, phase_limit);

            @(posedge i_clk);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                prev_echo = pick_echo(prev_echo);
                echo_backlog.push_back(prev_echo);
            end
            // pause the sender until every result of the phase is back
            wait_for_idle();
        end

        $display("Run covered %0d echo times over %0d register settings, both units,",
                 items_taken, NUM_PHASES + 2);
        $display("threshold edges and a %0d-cycle receiver hold; %0d results, %0d mismatches",
                 LONG_HOLD_CYCLES, results_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("** echo_distance_median_filter_unit: PASSED **");
        end else begin
            $display("** echo_distance_median_filter_unit: FAILED **");
        end
        $finish;
    end

endmodule
